[rtl/core/counting_sort_by_key_assert.svh]
// Assertion macros used by the checker of the counting sort block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COUNTING_SORT_BY_KEY_ASSERT_SVH
`define COUNTING_SORT_BY_KEY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSKEY_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSKEY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cskey_pkg.sv]
`default_nettype none

package cskey_pkg;

  localparam int KEY_W = 14;
  localparam int TAG_W = 6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             final_record;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             end_of_run;
    logic             dropped_any;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_BKT_RD,
    ST_BKT_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

[rtl/core/counting_sort_by_key.sv]
// Channel   Ports                           Transfer when
// input     start, busy, in_item            start high and busy low at a rising edge
// result    out_valid, out_item             out_valid high at a rising edge
//
// Records are loaded while busy is low. The record that carries final_record
// starts the sort: the block counts the keys, runs a prefix scan over the
// bucket memory, places the records, emits them and clears the used buckets.
// The scan and clear walk the key span from the minimum to the maximum key.
// After reset the whole bucket memory (2**KEY_BITS entries) is cleared,
// one entry per cycle, with busy high. The receiver cannot stall, so each
// result transfers in the cycle that out_valid marks.
`default_nettype none

module counting_sort_by_key #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 14
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  cskey_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output cskey_pkg::out_item_t out_item
);

  localparam int IDX_W     = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_RECORDS + 1);
  localparam int BKT_DEPTH = 1 << KEY_BITS;
  localparam int KEY_W     = cskey_pkg::KEY_W;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_RECORDS);

  // Control state.
  cskey_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;     // records held in this set
  logic                ovf_r;       // a record was dropped in this set
  logic [KEY_W-1:0]    lo_r, hi_r;  // running minimum and maximum key
  logic [CNT_W-1:0]    idx_r;       // record index for count, place and emit
  logic                pass_r;      // second record pass places the records
  logic [KEY_BITS-1:0] scan_r;      // bucket address for scan and clear
  logic [CNT_W-1:0]    run_r;       // running prefix sum
  logic                pend_v_r;    // a scan read is due for write-back
  logic                init_clr_r;  // the clear after reset covers all buckets
  logic                em_v_r;
  logic                em_last_r;

  // Payload registers.
  logic [KEY_BITS-1:0] pend_a_r;
  logic [KEY_BITS-1:0] b_r;

  // Memories and their registered read data.
  cskey_pkg::rec_t  rec_mem    [MAX_RECORDS];
  cskey_pkg::rec_t  placed_mem [MAX_RECORDS];
  logic [CNT_W-1:0] bkt_mem    [BKT_DEPTH];
  cskey_pkg::rec_t  rec_rd_r;
  cskey_pkg::rec_t  placed_rd_r;
  logic [CNT_W-1:0] bkt_rd_r;

  // Memory port controls.
  logic                rec_we;
  logic                pl_we;
  logic                bkt_we;
  logic [KEY_BITS-1:0] bkt_ra;
  logic [KEY_BITS-1:0] bkt_wa;
  logic [CNT_W-1:0]    bkt_wd;

  logic                accept;
  logic                has_room;
  logic [KEY_W-1:0]    k_in;
  logic [KEY_BITS-1:0] span;
  logic [KEY_BITS-1:0] rec_b;
  logic [KEY_BITS-1:0] clr_lim;
  logic                idx_last;

  assign busy     = (state_r != cskey_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign has_room = (count_r != MAX_CNT);
  assign k_in     = in_item.key & KEY_MASK;
  // Keys never fall below the minimum, so the differences are never negative.
  assign span     = KEY_BITS'(hi_r - lo_r);
  assign rec_b    = KEY_BITS'(rec_rd_r.key - lo_r);
  assign clr_lim  = init_clr_r ? {KEY_BITS{1'b1}} : span;
  assign idx_last = ((idx_r + CNT_W'(1)) == count_r);

  // Next state. The count and place passes share the three record states:
  // read the record, read its bucket, write the bucket back. One record is
  // finished before the next one reads, so back-to-back equal keys need no
  // forwarding.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cskey_pkg::ST_IDLE: begin
        if (accept && in_item.final_record) state_nxt = cskey_pkg::ST_REC_RD;
      end
      cskey_pkg::ST_REC_RD: state_nxt = cskey_pkg::ST_BKT_RD;
      cskey_pkg::ST_BKT_RD: state_nxt = cskey_pkg::ST_BKT_WR;
      cskey_pkg::ST_BKT_WR: begin
        if (!idx_last)   state_nxt = cskey_pkg::ST_REC_RD;
        else if (pass_r) state_nxt = cskey_pkg::ST_EMIT;
        else             state_nxt = cskey_pkg::ST_SCAN;
      end
      cskey_pkg::ST_SCAN: begin
        if (scan_r == span) state_nxt = cskey_pkg::ST_SCAN_END;
      end
      cskey_pkg::ST_SCAN_END: state_nxt = cskey_pkg::ST_REC_RD;
      cskey_pkg::ST_EMIT: begin
        if (idx_last) state_nxt = cskey_pkg::ST_CLEAR;
      end
      cskey_pkg::ST_CLEAR: begin
        if (scan_r == clr_lim) state_nxt = cskey_pkg::ST_IDLE;
      end
      default: state_nxt = cskey_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls for each state.
  always_comb begin
    rec_we = 1'b0;
    pl_we  = 1'b0;
    bkt_we = 1'b0;
    bkt_ra = scan_r;
    bkt_wa = scan_r;
    bkt_wd = '0;
    case (state_r)
      cskey_pkg::ST_IDLE: rec_we = accept && has_room;
      cskey_pkg::ST_BKT_RD: bkt_ra = rec_b;
      cskey_pkg::ST_BKT_WR: begin
        // In the count pass this bumps the count; in the place pass it
        // advances the start position of the bucket.
        bkt_we = 1'b1;
        bkt_wa = b_r;
        bkt_wd = bkt_rd_r + CNT_W'(1);
        pl_we  = pass_r && (bkt_rd_r < MAX_CNT);
      end
      cskey_pkg::ST_SCAN, cskey_pkg::ST_SCAN_END: begin
        // The scan writes back the bucket read in the previous cycle.
        bkt_we = pend_v_r;
        bkt_wa = pend_a_r;
        bkt_wd = run_r;
      end
      cskey_pkg::ST_CLEAR: bkt_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cskey_pkg::ST_CLEAR;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      lo_r       <= '0;
      hi_r       <= '0;
      idx_r      <= '0;
      pass_r     <= 1'b0;
      scan_r     <= '0;
      run_r      <= '0;
      pend_v_r   <= 1'b0;
      init_clr_r <= 1'b1;
      em_v_r     <= 1'b0;
      em_last_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      em_v_r   <= 1'b0;
      pend_v_r <= (state_r == cskey_pkg::ST_SCAN);
      case (state_r)
        cskey_pkg::ST_IDLE: begin
          if (accept) begin
            if (has_room) begin
              count_r <= count_r + CNT_W'(1);
              if (count_r == '0) begin
                lo_r <= k_in;
                hi_r <= k_in;
              end else begin
                if (k_in < lo_r) lo_r <= k_in;
                if (k_in > hi_r) hi_r <= k_in;
              end
            end else begin
              ovf_r <= 1'b1;
            end
            idx_r  <= '0;
            pass_r <= 1'b0;
          end
        end
        cskey_pkg::ST_BKT_WR: begin
          if (idx_last) begin
            idx_r  <= '0;
            scan_r <= '0;
            run_r  <= '0;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        cskey_pkg::ST_SCAN: begin
          if (pend_v_r) run_r <= run_r + bkt_rd_r;
          if (scan_r != span) scan_r <= scan_r + KEY_BITS'(1);
        end
        cskey_pkg::ST_SCAN_END: begin
          pass_r <= 1'b1;
          idx_r  <= '0;
        end
        cskey_pkg::ST_EMIT: begin
          em_v_r    <= 1'b1;
          em_last_r <= idx_last;
          if (idx_last) scan_r <= '0;
          else          idx_r  <= idx_r + CNT_W'(1);
        end
        cskey_pkg::ST_CLEAR: begin
          if (scan_r == clr_lim) begin
            count_r    <= '0;
            ovf_r      <= 1'b0;
            init_clr_r <= 1'b0;
          end else begin
            scan_r <= scan_r + KEY_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload captures for the scan write-back and the bucket of a record.
  always_ff @(posedge clk) begin
    pend_a_r <= scan_r;
    if (state_r == cskey_pkg::ST_BKT_RD) b_r <= rec_b;
  end

  // Record store: written while loading, read by record index.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[count_r[IDX_W-1:0]] <= '{key: k_in, tag: in_item.tag};
    end
    rec_rd_r <= rec_mem[idx_r[IDX_W-1:0]];
  end

  // Bucket store: counts, then start positions, then cleared again.
  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_rd_r <= bkt_mem[bkt_ra];
  end

  // Sorted records, written at their start positions and read out in order.
  always_ff @(posedge clk) begin
    if (pl_we) placed_mem[bkt_rd_r[IDX_W-1:0]] <= rec_rd_r;
    placed_rd_r <= placed_mem[idx_r[IDX_W-1:0]];
  end

  // The registered read of the sorted store is the output register.
  assign out_valid = em_v_r;
  always_comb begin
    out_item.sorted_key  = placed_rd_r.key;
    out_item.sorted_tag  = placed_rd_r.tag;
    out_item.end_of_run  = em_last_r;
    out_item.dropped_any = ovf_r;
  end

endmodule

`default_nettype wire

[rtl/core/cskey_check.sv]
`default_nettype none

`include "counting_sort_by_key_assert.svh"

module cskey_check (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input cskey_pkg::in_item_t  in_item,
  input wire                  out_valid,
  input cskey_pkg::out_item_t out_item
);

  // Transfers of a plain record and of the record that closes the set.
  logic rec_plain;
  logic rec_final;

  assign rec_plain = start && !busy && !in_item.final_record;
  assign rec_final = start && !busy && in_item.final_record;

  // Results appear only while a set is being sorted.
  `CSKEY_ASSERT_SAME(a_out_while_busy, out_valid, busy, "result outside a sort")

  // A record that does not close the set leaves the block ready.
  `CSKEY_ASSERT_NEXT(a_load_stays_ready, rec_plain, !busy, "busy after a plain record")

  // The closing record starts the sort.
  `CSKEY_ASSERT_NEXT(a_final_starts_sort, rec_final, busy, "final record did not start a sort")

  // Nothing follows the last result of a set.
  `CSKEY_ASSERT_NEXT(a_last_is_last, out_valid && out_item.end_of_run, !out_valid, "result after end of run")

endmodule

bind counting_sort_by_key cskey_check u_cskey_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
